### src/rrf_pkg.sv
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the
// read-request framer.
// ----------------------------------------------------------------------------
package rrf_pkg;

    localparam logic [7:0]  PREAMBLE_BYTE = 8'hAA;
    localparam logic [7:0]  OPCODE_READ   = 8'h09;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

    localparam int WC_W     = 7;
    localparam int ADDR_W   = 16;
    localparam int BYTE_W   = 8;

    // request queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    // byte kinds in the back-end sequencer
    localparam int KIND_W            = 3;
    localparam logic [KIND_W-1:0] K_START = 3'd0;
    localparam logic [KIND_W-1:0] K_PRE   = 3'd1;
    localparam logic [KIND_W-1:0] K_OP    = 3'd2;
    localparam logic [KIND_W-1:0] K_LEN   = 3'd3;
    localparam logic [KIND_W-1:0] K_ALO   = 3'd4;
    localparam logic [KIND_W-1:0] K_AHI   = 3'd5;
    localparam logic [KIND_W-1:0] K_CLO   = 3'd6;
    localparam logic [KIND_W-1:0] K_CHI   = 3'd7;

    // one classified request
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              first;   // opens a frame: header goes out first
        logic              last;    // closes a frame: CRC goes out after
        logic [BYTE_W-1:0] len;     // length byte, 2 * word count
    } t_req;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### src/rrf_front.sv
// ----------------------------------------------------------------------------
// rrf_front
// Holds the word count register, tracks the position within the frame and
// tags each incoming address as first and/or last of its frame.
// ----------------------------------------------------------------------------
module rrf_front import rrf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WC_W-1:0]   i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_q_full,
    output logic              o_push,
    output t_req              o_req
);

    logic [WC_W-1:0] r_word_count;
    logic [WC_W-1:0] r_words_taken;
    logic [WC_W-1:0] n_words_taken;
    logic [WC_W-1:0] wc_eff;
    logic            is_last;

    // a count of zero behaves as one
    assign wc_eff  = (r_word_count == '0) ? WC_W'(1) : r_word_count;
    assign is_last = ({1'b0, r_words_taken} + 8'd1) >= {1'b0, wc_eff};

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    assign o_req.addr  = i_addr;
    assign o_req.first = (r_words_taken == '0);
    assign o_req.last  = is_last;
    assign o_req.len   = {wc_eff, 1'b0};

    assign n_words_taken = is_last ? '0 : r_words_taken + WC_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count  <= WC_W'(1);
            r_words_taken <= '0;
        end else begin
            if (i_cfg_we) begin
                r_word_count <= i_cfg_wdata;
            end
            if (o_push) begin
                r_words_taken <= n_words_taken;
            end
        end
    end

`ifndef ASSERT_OFF
    a_first_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && is_last |=> r_words_taken == '0)
        else $error("frame position not cleared after last request");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !is_last |=> r_words_taken != '0)
        else $error("frame position lost within a frame");
`endif

endmodule

### src/rrf_queue.sv
// ----------------------------------------------------------------------------
// rrf_queue
// Short register FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module rrf_queue import rrf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_req o_req
);

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_mem[r_rptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request queue underflow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) || (r_cnt == QCNT_W'(QDEPTH)) |-> r_wptr == r_rptr)
        else $error("queue pointers out of step with count");
`endif

endmodule

### src/rrf_back.sv
// ----------------------------------------------------------------------------
// rrf_back
// Byte sequencer: walks header, address and CRC bytes of the head request,
// folds header and address bytes into the CRC and drives the output register.
// ----------------------------------------------------------------------------
module rrf_back import rrf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_req              i_req,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_byte,
    output logic              o_run_last,
    output logic              o_frame_last
);

    logic [KIND_W-1:0] r_kind;
    logic [KIND_W-1:0] kind;
    logic [KIND_W-1:0] n_kind;
    logic [15:0]       r_crc;
    logic [15:0]       n_crc;
    logic [BYTE_W-1:0] byte_sel;
    logic              emit;
    logic              done;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_run_last;
    logic              r_out_frame_last;

    assign emit = i_q_valid && (!r_out_valid || i_ready);
    assign kind = (r_kind == K_START) ? (i_req.first ? K_PRE : K_ALO) : r_kind;
    assign done = ((kind == K_AHI) && !i_req.last) || (kind == K_CHI);
    assign o_pop = emit && done;

    always_comb begin
        byte_sel = '0;
        n_kind   = K_START;
        n_crc    = r_crc;
        unique case (kind)
            K_PRE: begin
                byte_sel = PREAMBLE_BYTE;
                n_kind   = K_OP;
                n_crc    = crc_update(CRC_INIT, PREAMBLE_BYTE);
            end
            K_OP: begin
                byte_sel = OPCODE_READ;
                n_kind   = K_LEN;
                n_crc    = crc_update(r_crc, OPCODE_READ);
            end
            K_LEN: begin
                byte_sel = i_req.len;
                n_kind   = K_ALO;
                n_crc    = crc_update(r_crc, i_req.len);
            end
            K_ALO: begin
                byte_sel = i_req.addr[7:0];
                n_kind   = K_AHI;
                n_crc    = crc_update(r_crc, i_req.addr[7:0]);
            end
            K_AHI: begin
                byte_sel = i_req.addr[15:8];
                n_kind   = i_req.last ? K_CLO : K_START;
                n_crc    = crc_update(r_crc, i_req.addr[15:8]);
            end
            K_CLO: begin
                byte_sel = r_crc[7:0];
                n_kind   = K_CHI;
            end
            K_CHI: begin
                byte_sel = r_crc[15:8];
                n_kind   = K_START;
                n_crc    = CRC_INIT;
            end
            default: begin
                byte_sel = '0;
                n_kind   = K_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= K_START;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_kind      <= n_kind;
                r_crc       <= n_crc;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte       <= byte_sel;
            r_out_run_last   <= done;
            r_out_frame_last <= (kind == K_CHI);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte       = r_out_byte;
    assign o_run_last   = r_out_run_last;
    assign o_frame_last = r_out_frame_last;

`ifndef ASSERT_OFF
    a_frame_implies_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_last |-> o_run_last)
        else $error("frame end without run end");
    a_crc_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (kind == K_CHI) |=> r_crc == CRC_INIT)
        else $error("CRC not reloaded after frame");
    a_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> r_kind == K_START)
        else $error("sequencer mid-request with empty queue");
`endif

endmodule

### src/read_request_framer_crc16.sv
// ----------------------------------------------------------------------------
// read_request_framer_crc16
// Builds read-individual-registers request frames with a CRC-16/MODBUS tail.
// ----------------------------------------------------------------------------
// Each request on the slave side carries one 16-bit register address. The
// first address of a frame is preceded by 0xAA, 0x09 and a length byte of
// twice the word count (a count of zero acts as one); each address goes out
// low byte first; after the word-count-th address the CRC-16/MODBUS of all
// frame bytes follows, low byte first. tlast marks the final byte caused by
// one address, tuser[0] the final CRC byte of the frame. The master side
// moves one byte per cycle while tready is high and a request is queued; an
// address causes two bytes, five when it opens a frame and two more when it
// closes one; a two-entry request queue lets the next address be taken while
// the sequencer is busy. Write the word count only while no bytes are pending.
module read_request_framer_crc16 import rrf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [WC_W-1:0]   i_cfg_wdata,      // word_count
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [ADDR_W-1:0] i_s_axis_tdata,   // [15:0] reg_address
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,   // [7:0] tx_byte
    output logic              o_m_axis_tlast,   // run_last
    output logic [0:0]        o_m_axis_tuser    // [0] frame_last
);

    t_req front_req;
    t_req head_req;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    logic frame_last;

    rrf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_addr      (i_s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_req       (front_req)
    );

    rrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_req   (head_req)
    );

    rrf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_req        (head_req),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_run_last   (o_m_axis_tlast),
        .o_frame_last (frame_last)
    );

    assign o_m_axis_tuser = frame_last;

endmodule
